// ===== design/tnat_pkg.sv =====
// Shared types, constants and register indexes of the TCP NAT connection table.
// No dependencies; imported by tnat_front, tnat_back and the top level.
package tnat_pkg;

  // Default sizes handed down from the top level
  localparam int TABLE_ENTRIES_DEF = 64;
  localparam int POOL_FIRST_DEF    = 12345;
  localparam int POOL_LAST_DEF     = 23456;

  // Configuration port geometry and register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam logic [CFG_IDX_W-1:0] CFG_PUBLIC_IP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RULE_COUNT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RULE0_MATCH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RULE0_TARGET = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RULE1_MATCH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RULE1_TARGET = 3'd6;

  localparam logic [15:0] IDLE_TIMEOUT_RST = 16'd60;
  localparam int POOL_WORD_W = 64;

  // Item classes decided at the front
  typedef enum logic [1:0] {
    KIND_OUT  = 2'd0,
    KIND_IN   = 2'd1,
    KIND_TICK = 2'd2
  } kind_e;

  // Result actions
  typedef enum logic [1:0] {
    ACT_FWD    = 2'd0,
    ACT_POOL   = 2'd1,
    ACT_NORULE = 2'd2,
    ACT_FULL   = 2'd3
  } action_e;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] seq_num;
    logic [31:0] ack_num;
    logic [15:0] payload_bytes;
    logic        syn;
    logic        fin;
    logic        ack;
  } item_t;

  typedef struct packed {
    logic [31:0] public_ip;
    logic [15:0] idle_timeout;
    logic [1:0]  rule_count;
    logic [47:0] rule0_match;
    logic [47:0] rule0_target;
    logic [47:0] rule1_match;
    logic [47:0] rule1_target;
  } cfg_t;

  typedef struct packed {
    action_e     action;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
  } result_t;

endpackage

// ===== design/tnat_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tnat_ram #(
  parameter int Width = 8,
  parameter int Depth = 2,
  localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write and register the read data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/tnat_front.sv =====
// Front end: accepts items, classifies them and holds them in a two-deep queue.
// Depends on tnat_pkg.
module tnat_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            hold_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            opcode_i,
  input  logic            direction_i,
  input  logic [31:0]     src_ip_i,
  input  logic [31:0]     dst_ip_i,
  input  logic [15:0]     src_port_i,
  input  logic [15:0]     dst_port_i,
  input  logic [31:0]     seq_num_i,
  input  logic [31:0]     ack_num_i,
  input  logic [15:0]     payload_bytes_i,
  input  logic            syn_bit_i,
  input  logic            fin_bit_i,
  input  logic            ack_bit_i,
  output logic            q_valid_o,
  output tnat_pkg::item_t q_item_o,
  input  logic            q_pop_i
);
  import tnat_pkg::*;

  item_t       slot_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;
  logic        push, pop;
  item_t       item_in;

  // Classify the incoming item
  always_comb begin
    item_in               = '0;
    item_in.kind          = opcode_i ? KIND_TICK : (direction_i ? KIND_IN : KIND_OUT);
    item_in.src_ip        = src_ip_i;
    item_in.dst_ip        = dst_ip_i;
    item_in.src_port      = src_port_i;
    item_in.dst_port      = dst_port_i;
    item_in.seq_num       = seq_num_i;
    item_in.ack_num       = ack_num_i;
    item_in.payload_bytes = payload_bytes_i;
    item_in.syn           = syn_bit_i;
    item_in.fin           = fin_bit_i;
    item_in.ack           = ack_bit_i;
  end

  assign in_stall_o = hold_i || (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = q_pop_i && (cnt_q != 2'd0);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = slot_q[rd_ptr_q];

  // Store the payload
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= item_in;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== design/tnat_back.sv =====
// Back end: sequencer over the connection table and the pool bitmap, both in RAM.
// Depends on tnat_pkg and tnat_ram.
module tnat_back #(
  parameter int TableEntries = tnat_pkg::TABLE_ENTRIES_DEF,
  parameter int PoolFirst    = tnat_pkg::POOL_FIRST_DEF,
  parameter int PoolLast     = tnat_pkg::POOL_LAST_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tnat_pkg::cfg_t    cfg_i,
  input  logic              q_valid_i,
  input  tnat_pkg::item_t   q_item_i,
  output logic              q_pop_o,
  output logic              clearing_o,
  output logic              res_valid_o,
  output tnat_pkg::result_t res_o,
  input  logic              res_stall_i
);
  import tnat_pkg::*;

  typedef struct packed {
    logic        valid;
    logic        owns;
    logic [47:0] priv;
    logic [47:0] pub;
    logic [47:0] peer;
    logic [31:0] last_seen;
    logic [31:0] in_seq_end;
    logic [31:0] in_ack;
    logic [31:0] out_seq_end;
    logic [31:0] out_ack;
    logic [1:0]  fin_marks;
  } entry_t;

  localparam int  EntryW    = $bits(entry_t);
  localparam int  EntryAw   = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int  IdxW      = $clog2(TableEntries + 1);
  localparam bit  PoolEmpty = (PoolLast < PoolFirst);
  localparam int  PoolSize  = PoolEmpty ? 1 : (PoolLast - PoolFirst + 1);
  localparam int  PoolWords = (PoolSize + POOL_WORD_W - 1) / POOL_WORD_W;
  localparam int  WordAw    = (PoolWords > 1) ? $clog2(PoolWords) : 1;
  localparam int  WcW       = $clog2(PoolWords + 1);
  localparam int  ClrCount  = (TableEntries > PoolWords) ? TableEntries : PoolWords;
  localparam int  ClrW      = $clog2(ClrCount + 1);
  localparam int  TailBits  = PoolSize % POOL_WORD_W;
  localparam logic [POOL_WORD_W-1:0] TailMask =
      (TailBits == 0) ? '0 : ~((64'd1 << TailBits) - 64'd1);

  typedef enum logic [8:0] {
    ST_CLEAR   = 9'b000000001,
    ST_IDLE    = 9'b000000010,
    ST_SCAN    = 9'b000000100,
    ST_FREE_RD = 9'b000001000,
    ST_FREE_WR = 9'b000010000,
    ST_POOL    = 9'b000100000,
    ST_DECIDE  = 9'b001000000,
    ST_WRITE   = 9'b010000000,
    ST_RESULT  = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  item_t  item_q, item_d;
  entry_t ent_q, ent_d;
  logic [IdxW-1:0]    idx_q, idx_d, idx_nxt;
  logic [WcW-1:0]     wc_q, wc_d, wc_nxt;
  logic [ClrW-1:0]    clr_q, clr_d;
  logic [31:0]        now_q, now_d;
  logic               dv_q, dv_d, pdv_q, pdv_d;
  logic               hit_q, hit_d, free_found_q, free_found_d, pool_found_q, pool_found_d;
  logic [EntryAw-1:0] slot_q, slot_d;
  logic [15:0]        port_q, port_d;
  logic [POOL_WORD_W-1:0] pword_q, pword_d;
  logic [WordAw-1:0]  pwaddr_q, pwaddr_d;
  logic [5:0]         pbit_q, pbit_d, bitpos;
  result_t            res_pend_q, res_pend_d, res_q;
  logic               res_valid_q, res_load;

  logic               ent_we, pool_we;
  logic [EntryAw-1:0] ent_waddr, ent_raddr;
  logic [EntryW-1:0]  ent_rdata;
  entry_t             ent_wdata, ent_rd, ent_new, ent_upd;
  logic [WordAw-1:0]  pool_waddr, pool_raddr;
  logic [POOL_WORD_W-1:0] pool_wdata, pool_rd, pool_masked;
  logic [15:0]        free_off;
  logic [WordAw-1:0]  free_word;
  logic [5:0]         free_bit;
  logic               finished, idle, remove, match, r0, r1;
  logic [31:0]        seq_end;

  tnat_ram #(.Width(EntryW), .Depth(TableEntries)) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  tnat_ram #(.Width(POOL_WORD_W), .Depth(PoolWords)) u_pool_ram (
    .clk_i   (clk_i),
    .we_i    (pool_we),
    .waddr_i (pool_waddr),
    .wdata_i (pool_wdata),
    .raddr_i (pool_raddr),
    .rdata_o (pool_rd)
  );

  assign ent_rd  = entry_t'(ent_rdata);
  assign idx_nxt = idx_q + 1'b1;
  assign wc_nxt  = wc_q + 1'b1;

  // Removal test for the entry on the read port
  assign finished = (ent_rd.fin_marks == 2'b11) &&
                    (ent_rd.in_ack >= ent_rd.out_seq_end) &&
                    (ent_rd.out_ack >= ent_rd.in_seq_end);
  assign idle     = (now_q - ent_rd.last_seen) >= {16'b0, cfg_i.idle_timeout};
  assign remove   = ent_rd.valid && (finished || idle);

  // Lookup match for the current packet
  always_comb begin
    if (item_q.kind == KIND_OUT) begin
      match = ent_rd.valid && (ent_rd.priv == {item_q.src_ip, item_q.src_port}) &&
              (ent_rd.peer == {item_q.dst_ip, item_q.dst_port});
    end else begin
      match = ent_rd.valid && (ent_rd.pub == {item_q.dst_ip, item_q.dst_port}) &&
              (ent_rd.peer == {item_q.src_ip, item_q.src_port});
    end
  end

  // DNAT rules; a count of three acts as two
  assign r0 = (cfg_i.rule_count != 2'd0) &&
              (cfg_i.rule0_match == {item_q.dst_ip, item_q.dst_port});
  assign r1 = cfg_i.rule_count[1] &&
              (cfg_i.rule1_match == {item_q.dst_ip, item_q.dst_port});

  // Pool word and bit of a port being released
  assign free_off  = port_q - 16'(PoolFirst);
  assign free_word = free_off[6 +: WordAw];
  assign free_bit  = free_off[5:0];

  // Lowest clear bit of the pool word on the read port
  always_comb begin
    pool_masked = pool_rd | ((wc_q == WcW'(PoolWords - 1)) ? TailMask : '0);
    bitpos = '0;
    for (int b = POOL_WORD_W - 1; b >= 0; b--) begin
      if (!pool_masked[b]) bitpos = 6'(b);
    end
  end

  // New entry built from the packet on a miss
  always_comb begin
    ent_new       = '0;
    ent_new.valid = 1'b1;
    if (item_q.kind == KIND_OUT) begin
      ent_new.owns = 1'b1;
      ent_new.priv = {item_q.src_ip, item_q.src_port};
      ent_new.pub  = {cfg_i.public_ip, port_q};
      ent_new.peer = {item_q.dst_ip, item_q.dst_port};
    end else begin
      ent_new.priv = r0 ? cfg_i.rule0_target : cfg_i.rule1_target;
      ent_new.pub  = {item_q.dst_ip, item_q.dst_port};
      ent_new.peer = {item_q.src_ip, item_q.src_port};
    end
  end

  // Tracking update of the held entry
  always_comb begin
    seq_end = item_q.seq_num + {16'b0, item_q.payload_bytes} +
              {31'b0, item_q.syn | item_q.fin};
    ent_upd = ent_q;
    ent_upd.last_seen = now_q;
    if (item_q.kind == KIND_OUT) begin
      if (seq_end > ent_q.out_seq_end) ent_upd.out_seq_end = seq_end;
      if (item_q.ack) ent_upd.out_ack = item_q.ack_num;
      if (item_q.fin) ent_upd.fin_marks[0] = 1'b1;
    end else begin
      if (seq_end > ent_q.in_seq_end) ent_upd.in_seq_end = seq_end;
      if (item_q.ack) ent_upd.in_ack = item_q.ack_num;
      if (item_q.fin) ent_upd.fin_marks[1] = 1'b1;
    end
  end

  // Sequencer
  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    ent_d        = ent_q;
    idx_d        = idx_q;
    wc_d         = wc_q;
    clr_d        = clr_q;
    now_d        = now_q;
    dv_d         = dv_q;
    pdv_d        = pdv_q;
    hit_d        = hit_q;
    free_found_d = free_found_q;
    pool_found_d = pool_found_q;
    slot_d       = slot_q;
    port_d       = port_q;
    pword_d      = pword_q;
    pwaddr_d     = pwaddr_q;
    pbit_d       = pbit_q;
    res_pend_d   = res_pend_q;
    res_load     = 1'b0;
    q_pop_o      = 1'b0;
    ent_we       = 1'b0;
    ent_waddr    = slot_q;
    ent_wdata    = ent_upd;
    ent_raddr    = idx_q[EntryAw-1:0];
    pool_we      = 1'b0;
    pool_waddr   = pwaddr_q;
    pool_wdata   = pword_q | (64'd1 << pbit_q);
    pool_raddr   = wc_q[WordAw-1:0];
    case (state_q)
      ST_CLEAR: begin
        ent_we     = (clr_q < ClrW'(TableEntries));
        ent_waddr  = clr_q[EntryAw-1:0];
        ent_wdata  = '0;
        pool_we    = (clr_q < ClrW'(PoolWords));
        pool_waddr = clr_q[WordAw-1:0];
        pool_wdata = '0;
        clr_d      = clr_q + 1'b1;
        if (clr_q == ClrW'(ClrCount - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o      = 1'b1;
          item_d       = q_item_i;
          idx_d        = '0;
          dv_d         = 1'b0;
          hit_d        = 1'b0;
          free_found_d = 1'b0;
          pool_found_d = 1'b0;
          if (q_item_i.kind == KIND_TICK) now_d = now_q + 32'd1;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (idx_q == IdxW'(TableEntries)) begin
          if (item_q.kind == KIND_TICK) begin
            state_d = ST_IDLE;
          end else if (item_q.kind == KIND_OUT && !PoolEmpty) begin
            wc_d    = '0;
            pdv_d   = 1'b0;
            state_d = ST_POOL;
          end else begin
            state_d = ST_DECIDE;
          end
        end else if (!dv_q) begin
          dv_d = 1'b1;
        end else begin
          idx_d     = idx_nxt;
          ent_raddr = idx_nxt[EntryAw-1:0];
          if (item_q.kind == KIND_TICK) begin
            if (remove) begin
              ent_we          = 1'b1;
              ent_waddr       = idx_q[EntryAw-1:0];
              ent_wdata       = ent_rd;
              ent_wdata.valid = 1'b0;
              ent_wdata.owns  = 1'b0;
              if (ent_rd.owns) begin
                port_d  = ent_rd.pub[15:0];
                dv_d    = 1'b0;
                state_d = ST_FREE_RD;
              end
            end
          end else if (match) begin
            hit_d   = 1'b1;
            slot_d  = idx_q[EntryAw-1:0];
            ent_d   = ent_rd;
            state_d = ST_DECIDE;
          end else if (!ent_rd.valid && !free_found_q) begin
            free_found_d = 1'b1;
            slot_d       = idx_q[EntryAw-1:0];
          end
        end
      end
      ST_FREE_RD: begin
        pool_raddr = free_word;
        state_d    = ST_FREE_WR;
      end
      ST_FREE_WR: begin
        pool_we    = 1'b1;
        pool_waddr = free_word;
        pool_wdata = pool_rd & ~(64'd1 << free_bit);
        state_d    = ST_SCAN;
      end
      ST_POOL: begin
        if (wc_q == WcW'(PoolWords)) begin
          state_d = ST_DECIDE;
        end else if (!pdv_q) begin
          pdv_d = 1'b1;
        end else if (pool_masked != '1) begin
          pool_found_d = 1'b1;
          port_d       = 16'(PoolFirst) + 16'({wc_q[WordAw-1:0], bitpos});
          pword_d      = pool_rd;
          pwaddr_d     = wc_q[WordAw-1:0];
          pbit_d       = bitpos;
          state_d      = ST_DECIDE;
        end else begin
          wc_d       = wc_nxt;
          pool_raddr = wc_nxt[WordAw-1:0];
        end
      end
      ST_DECIDE: begin
        res_pend_d = '0;
        state_d    = ST_RESULT;
        if (hit_q) begin
          state_d = ST_WRITE;
        end else if (item_q.kind == KIND_OUT) begin
          if (!pool_found_q) begin
            res_pend_d.action = ACT_POOL;
          end else if (!free_found_q) begin
            res_pend_d.action = ACT_FULL;
          end else begin
            pool_we = 1'b1;
            ent_d   = ent_new;
            state_d = ST_WRITE;
          end
        end else begin
          if (!(r0 || r1)) begin
            res_pend_d.action = ACT_NORULE;
          end else if (!free_found_q) begin
            res_pend_d.action = ACT_FULL;
          end else begin
            ent_d   = ent_new;
            state_d = ST_WRITE;
          end
        end
      end
      ST_WRITE: begin
        ent_we            = 1'b1;
        res_pend_d.action = ACT_FWD;
        if (item_q.kind == KIND_OUT) begin
          res_pend_d.src_ip   = ent_q.pub[47:16];
          res_pend_d.dst_ip   = item_q.dst_ip;
          res_pend_d.src_port = ent_q.pub[15:0];
          res_pend_d.dst_port = item_q.dst_port;
        end else begin
          res_pend_d.src_ip   = item_q.src_ip;
          res_pend_d.dst_ip   = ent_q.priv[47:16];
          res_pend_d.src_port = item_q.src_port;
          res_pend_d.dst_port = ent_q.priv[15:0];
        end
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (!res_valid_q || !res_stall_i) begin
          res_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      idx_q        <= '0;
      wc_q         <= '0;
      clr_q        <= '0;
      now_q        <= '0;
      dv_q         <= 1'b0;
      pdv_q        <= 1'b0;
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
      pool_found_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      wc_q         <= wc_d;
      clr_q        <= clr_d;
      now_q        <= now_d;
      dv_q         <= dv_d;
      pdv_q        <= pdv_d;
      hit_q        <= hit_d;
      free_found_q <= free_found_d;
      pool_found_q <= pool_found_d;
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (!res_stall_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    ent_q      <= ent_d;
    slot_q     <= slot_d;
    port_q     <= port_d;
    pword_q    <= pword_d;
    pwaddr_q   <= pwaddr_d;
    pbit_q     <= pbit_d;
    res_pend_q <= res_pend_d;
    if (res_load) res_q <= res_pend_q;
  end

  assign clearing_o  = (state_q == ST_CLEAR);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ===== design/tcp_nat_connection_table_top.sv =====
// Top level of the TCP NAT connection table: configuration registers, front queue
// and back-end sequencer. Depends on tnat_pkg, tnat_front and tnat_back.
//
// Usage: the input channel (in_valid_i / in_stall_o) carries either a TCP header
// to translate (opcode 0) or a one-second tick (opcode 1). Each header gives one
// result on the output channel (out_valid_o / out_stall_i); a tick gives none.
// Registers must be written by the user through cfg_we_i / cfg_index_i /
// cfg_data_i while idle; the block itself does not enforce this. The table RAM
// read port gives one entry per cycle: a packet that hits entry k stops its scan
// there, a miss walks the whole table, and an outbound miss then walks the
// pool bitmap, one 64-port word a cycle, until it finds a free port or its end.
// A tick walks the table and frees the pool port of each owning entry it removes.
// Reset: a clearing pass over max(TableEntries, ceil(pool size / 64)) RAM words
// zeroes the table and pool RAMs; in_stall_o stays high until it ends.
// A two-deep queue takes items while the back end works, and the output register
// holds a result while out_stall_i is high, with the next item already in work.
module tcp_nat_connection_table_top #(
  parameter int TableEntries = tnat_pkg::TABLE_ENTRIES_DEF,
  parameter int PoolFirst    = tnat_pkg::POOL_FIRST_DEF,
  parameter int PoolLast     = tnat_pkg::POOL_LAST_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tnat_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tnat_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            opcode_i,
  input  logic                            direction_i,
  input  logic [31:0]                     src_ip_i,
  input  logic [31:0]                     dst_ip_i,
  input  logic [15:0]                     src_port_i,
  input  logic [15:0]                     dst_port_i,
  input  logic [31:0]                     seq_num_i,
  input  logic [31:0]                     ack_num_i,
  input  logic [15:0]                     payload_bytes_i,
  input  logic                            syn_bit_i,
  input  logic                            fin_bit_i,
  input  logic                            ack_bit_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [1:0]                      action_o,
  output logic [31:0]                     out_src_ip_o,
  output logic [31:0]                     out_dst_ip_o,
  output logic [15:0]                     out_src_port_o,
  output logic [15:0]                     out_dst_port_o
);
  import tnat_pkg::*;

  cfg_t    cfg_q;
  item_t   q_item;
  result_t res;
  logic    q_valid, q_pop, clearing;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= {32'd0, IDLE_TIMEOUT_RST, 194'd0};
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PUBLIC_IP:    cfg_q.public_ip    <= cfg_data_i[31:0];
        CFG_IDLE_TIMEOUT: cfg_q.idle_timeout <= cfg_data_i[15:0];
        CFG_RULE_COUNT:   cfg_q.rule_count   <= cfg_data_i[1:0];
        CFG_RULE0_MATCH:  cfg_q.rule0_match  <= cfg_data_i;
        CFG_RULE0_TARGET: cfg_q.rule0_target <= cfg_data_i;
        CFG_RULE1_MATCH:  cfg_q.rule1_match  <= cfg_data_i;
        CFG_RULE1_TARGET: cfg_q.rule1_target <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tnat_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .hold_i          (clearing),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .opcode_i        (opcode_i),
    .direction_i     (direction_i),
    .src_ip_i        (src_ip_i),
    .dst_ip_i        (dst_ip_i),
    .src_port_i      (src_port_i),
    .dst_port_i      (dst_port_i),
    .seq_num_i       (seq_num_i),
    .ack_num_i       (ack_num_i),
    .payload_bytes_i (payload_bytes_i),
    .syn_bit_i       (syn_bit_i),
    .fin_bit_i       (fin_bit_i),
    .ack_bit_i       (ack_bit_i),
    .q_valid_o       (q_valid),
    .q_item_o        (q_item),
    .q_pop_i         (q_pop)
  );

  tnat_back #(
    .TableEntries (TableEntries),
    .PoolFirst    (PoolFirst),
    .PoolLast     (PoolLast)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .clearing_o  (clearing),
    .res_valid_o (out_valid_o),
    .res_o       (res),
    .res_stall_i (out_stall_i)
  );

  assign action_o       = res.action;
  assign out_src_ip_o   = res.src_ip;
  assign out_dst_ip_o   = res.dst_ip;
  assign out_src_port_o = res.src_port;
  assign out_dst_port_o = res.dst_port;

  // No item enters while the RAMs are being cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni) clearing |-> in_stall_o)
    else $error("item accepted during clearing pass");

  // A dropped packet carries all-zero addresses and ports
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && (action_o != ACT_FWD)) |->
      (out_src_ip_o == 32'd0 && out_dst_ip_o == 32'd0 &&
       out_src_port_o == 16'd0 && out_dst_port_o == 16'd0))
    else $error("dropped result with non-zero fields");

endmodule
